// ===== rtl/dld_pkg.sv =====
`timescale 1ns / 1ps
// shared types, opcodes and constants of the dex debug line program decoder
package dld_pkg;

  // default limit on line entries per stream
  localparam int unsigned MAX_ENTRIES_DEF = 256;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // line program opcodes
  localparam logic [7:0] OP_END_SEQUENCE   = 8'h00;
  localparam logic [7:0] OP_ADVANCE_PC     = 8'h01;
  localparam logic [7:0] OP_ADVANCE_LINE   = 8'h02;
  localparam logic [7:0] OP_START_LOCAL    = 8'h03;
  localparam logic [7:0] OP_START_LOCAL_EX = 8'h04;
  localparam logic [7:0] OP_SET_PROLOGUE   = 8'h07;
  localparam logic [7:0] OP_SET_EPILOGUE   = 8'h08;
  localparam logic [7:0] OP_FIRST_SPECIAL  = 8'h0A;

  // special opcode line mapping
  localparam logic [31:0] LINE_BASE  = 32'hFFFF_FFFC;  // -4
  localparam logic [7:0]  LINE_RANGE = 8'd15;
  // adj / 15 == (adj * 137) >> 11 for every adj below 256
  localparam logic [15:0] RECIP_15    = 16'd137;
  localparam int unsigned RECIP_SHIFT = 11;

  // record kinds
  localparam logic [1:0] REC_LINE     = 2'd0;
  localparam logic [1:0] REC_PROLOGUE = 2'd1;
  localparam logic [1:0] REC_END      = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         record_kind;
    logic [31:0]        code_address;
    logic signed [31:0] source_line;
    logic               last_record;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_INIT,
    CMD_SPECIAL,
    CMD_ADD_ADDR,
    CMD_ADD_LINE,
    CMD_PROLOGUE,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] addr_add;
    logic [31:0] line_add;
  } cmd_t;

  // a command together with its valid flag, front to queue and queue to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

// ===== rtl/dld_front.sv =====
`timescale 1ns / 1ps
// front end: byte parser for header, leb operands and opcodes
module dld_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dld_pkg::in_item_t   in_item,
  input  logic                q_full,
  output dld_pkg::cmd_slot_t  push
);

  typedef enum logic [2:0] {
    PH_START_LINE,
    PH_PARAM_COUNT,
    PH_PARAM_SKIP,
    PH_OPCODE,
    PH_OPERAND,
    PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  shift_r, shift_nxt;
  logic [2:0]  ops_left_r, ops_left_nxt;
  logic [7:0]  pend_op_r, pend_op_nxt;
  logic [31:0] params_r, params_nxt;

  phase_t      eff_phase;
  logic [31:0] eff_acc;
  logic [5:0]  eff_shift;
  logic [2:0]  eff_ops;
  logic [7:0]  eff_pend;
  logic [31:0] eff_params;

  logic [7:0]  b;
  logic [31:0] acc_take;
  logic [5:0]  shift_take;
  logic        leb_done;
  logic [31:0] sleb_val;
  logic [7:0]  adj;
  logic [15:0] prod;
  logic [4:0]  quo;
  logic [3:0]  rem;
  logic [2:0]  ops_dec;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_item.data_byte;

  always_comb begin
    // stream start clears the parser before the byte is taken
    if (in_item.stream_start) begin
      eff_phase  = PH_START_LINE;
      eff_acc    = '0;
      eff_shift  = '0;
      eff_ops    = '0;
      eff_pend   = '0;
      eff_params = '0;
    end else begin
      eff_phase  = phase_r;
      eff_acc    = acc_r;
      eff_shift  = shift_r;
      eff_ops    = ops_left_r;
      eff_pend   = pend_op_r;
      eff_params = params_r;
    end

    // leb step, payload past bit 31 dropped
    acc_take   = (eff_shift < 6'd32) ? (eff_acc | ({25'd0, b[6:0]} << eff_shift[4:0]))
                                     : eff_acc;
    shift_take = (eff_shift < 6'd32) ? eff_shift + 6'd7 : 6'd35;
    leb_done   = !b[7];
    sleb_val   = acc_take;
    if (shift_take < 6'd32 && b[6]) begin
      sleb_val = acc_take | (32'hFFFF_FFFF << shift_take[4:0]);
    end

    // special opcode split by 15
    adj  = b - dld_pkg::OP_FIRST_SPECIAL;
    prod = {8'd0, adj} * dld_pkg::RECIP_15;
    quo  = 5'(prod >> dld_pkg::RECIP_SHIFT);
    rem  = 4'(adj - 8'({3'd0, quo} * dld_pkg::LINE_RANGE));

    ops_dec = (eff_ops != 3'd0) ? eff_ops - 3'd1 : 3'd0;

    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    shift_nxt    = shift_r;
    ops_left_nxt = ops_left_r;
    pend_op_nxt  = pend_op_r;
    params_nxt   = params_r;
    push         = '0;
    push.cmd.kind = dld_pkg::CMD_INIT;

    if (accept) begin
      phase_nxt    = eff_phase;
      acc_nxt      = eff_acc;
      shift_nxt    = eff_shift;
      ops_left_nxt = eff_ops;
      pend_op_nxt  = eff_pend;
      params_nxt   = eff_params;
      case (eff_phase)
        PH_START_LINE: begin
          acc_nxt   = acc_take;
          shift_nxt = shift_take;
          if (leb_done) begin
            push.valid         = 1'b1;
            push.cmd.kind      = dld_pkg::CMD_INIT;
            push.cmd.line_add  = acc_take;
            acc_nxt            = '0;
            shift_nxt          = '0;
            phase_nxt          = PH_PARAM_COUNT;
          end
        end
        PH_PARAM_COUNT: begin
          acc_nxt   = acc_take;
          shift_nxt = shift_take;
          if (leb_done) begin
            params_nxt = acc_take;
            acc_nxt    = '0;
            shift_nxt  = '0;
            phase_nxt  = (acc_take != 32'd0) ? PH_PARAM_SKIP : PH_OPCODE;
          end
        end
        PH_PARAM_SKIP: begin
          acc_nxt   = acc_take;
          shift_nxt = shift_take;
          if (leb_done) begin
            acc_nxt    = '0;
            shift_nxt  = '0;
            params_nxt = eff_params - 32'd1;
            if (eff_params == 32'd1) begin
              phase_nxt = PH_OPCODE;
            end
          end
        end
        PH_OPCODE: begin
          if (b >= dld_pkg::OP_FIRST_SPECIAL) begin
            push.valid        = 1'b1;
            push.cmd.kind     = dld_pkg::CMD_SPECIAL;
            push.cmd.addr_add = {27'd0, quo};
            push.cmd.line_add = {28'd0, rem} + dld_pkg::LINE_BASE;
          end else begin
            pend_op_nxt = b;
            case (b)
              dld_pkg::OP_END_SEQUENCE: begin
                push.valid    = 1'b1;
                push.cmd.kind = dld_pkg::CMD_END;
                phase_nxt     = PH_DONE;
              end
              dld_pkg::OP_SET_PROLOGUE: begin
                push.valid    = 1'b1;
                push.cmd.kind = dld_pkg::CMD_PROLOGUE;
              end
              dld_pkg::OP_SET_EPILOGUE: begin
              end
              dld_pkg::OP_START_LOCAL: begin
                ops_left_nxt = 3'd3;
                acc_nxt      = '0;
                shift_nxt    = '0;
                phase_nxt    = PH_OPERAND;
              end
              dld_pkg::OP_START_LOCAL_EX: begin
                ops_left_nxt = 3'd4;
                acc_nxt      = '0;
                shift_nxt    = '0;
                phase_nxt    = PH_OPERAND;
              end
              default: begin
                ops_left_nxt = 3'd1;
                acc_nxt      = '0;
                shift_nxt    = '0;
                phase_nxt    = PH_OPERAND;
              end
            endcase
          end
        end
        PH_OPERAND: begin
          acc_nxt   = acc_take;
          shift_nxt = shift_take;
          if (leb_done) begin
            if (eff_pend == dld_pkg::OP_ADVANCE_PC) begin
              push.valid        = 1'b1;
              push.cmd.kind     = dld_pkg::CMD_ADD_ADDR;
              push.cmd.addr_add = acc_take;
            end else if (eff_pend == dld_pkg::OP_ADVANCE_LINE) begin
              push.valid        = 1'b1;
              push.cmd.kind     = dld_pkg::CMD_ADD_LINE;
              push.cmd.line_add = sleb_val;
            end
            acc_nxt      = '0;
            shift_nxt    = '0;
            ops_left_nxt = ops_dec;
            if (ops_dec == 3'd0) begin
              phase_nxt = PH_OPCODE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START_LINE;
      acc_r      <= '0;
      shift_r    <= '0;
      ops_left_r <= '0;
      pend_op_r  <= '0;
      params_r   <= '0;
    end else begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      shift_r    <= shift_nxt;
      ops_left_r <= ops_left_nxt;
      pend_op_r  <= pend_op_nxt;
      params_r   <= params_nxt;
    end
  end

endmodule

// ===== rtl/dld_fifo.sv =====
`timescale 1ns / 1ps
// short command queue between parser and executor
module dld_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  dld_pkg::cmd_slot_t push,
  input  logic               pop,
  output dld_pkg::cmd_slot_t head,
  output logic               full
);

  dld_pkg::cmd_t                  slots_r [dld_pkg::QUEUE_DEPTH];
  logic [dld_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [dld_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [dld_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count_r == dld_pkg::QCNT_W'(dld_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = slots_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/dld_back.sv =====
`timescale 1ns / 1ps
// back end: address and line registers, entry filter, output register
module dld_back #(
  parameter int unsigned MAX_ENTRIES = dld_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [31:0]        cfg_data,
  input  dld_pkg::cmd_slot_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output dld_pkg::out_item_t out_item
);

  localparam int unsigned ENT_W = $clog2(MAX_ENTRIES + 1);

  logic [31:0]        code_units_r;
  logic [31:0]        address_r, address_nxt;
  logic [31:0]        line_r, line_nxt;
  logic [ENT_W-1:0]   entries_r, entries_nxt;
  logic               out_valid_r, out_valid_nxt;
  dld_pkg::out_item_t out_item_r, out_item_nxt;
  logic [31:0]        addr_sum;
  logic [31:0]        line_sum;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign pop       = head.valid && (!out_valid_r || out_ready);
  assign addr_sum  = address_r + head.cmd.addr_add;
  assign line_sum  = line_r + head.cmd.line_add;

  always_comb begin
    address_nxt   = address_r;
    line_nxt      = line_r;
    entries_nxt   = entries_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      out_valid_nxt = 1'b0;
      case (head.cmd.kind)
        dld_pkg::CMD_INIT: begin
          address_nxt = '0;
          line_nxt    = head.cmd.line_add;
          entries_nxt = '0;
        end
        dld_pkg::CMD_SPECIAL: begin
          address_nxt = addr_sum;
          line_nxt    = line_sum;
          if (addr_sum < code_units_r && entries_r < ENT_W'(MAX_ENTRIES)) begin
            entries_nxt                = entries_r + 1'b1;
            out_valid_nxt              = 1'b1;
            out_item_nxt.record_kind   = dld_pkg::REC_LINE;
            out_item_nxt.code_address  = addr_sum;
            out_item_nxt.source_line   = line_sum;
            out_item_nxt.last_record   = 1'b0;
          end
        end
        dld_pkg::CMD_ADD_ADDR: begin
          address_nxt = addr_sum;
        end
        dld_pkg::CMD_ADD_LINE: begin
          line_nxt = line_sum;
        end
        dld_pkg::CMD_PROLOGUE: begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.record_kind  = dld_pkg::REC_PROLOGUE;
          out_item_nxt.code_address = address_r;
          out_item_nxt.source_line  = line_r;
          out_item_nxt.last_record  = 1'b0;
        end
        dld_pkg::CMD_END: begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.record_kind  = dld_pkg::REC_END;
          out_item_nxt.code_address = address_r;
          out_item_nxt.source_line  = line_r;
          out_item_nxt.last_record  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      code_units_r <= '0;
      address_r    <= '0;
      line_r       <= '0;
      entries_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        code_units_r <= cfg_data;
      end
      address_r   <= address_nxt;
      line_r      <= line_nxt;
      entries_r   <= entries_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/dex_debug_line_program_decoder_unit.sv =====
`timescale 1ns / 1ps
// top level of the dex debug line program decoder
// a byte's command is registered in the queue, then its record in the output register that drives out_valid
// throughput: one byte per cycle while the command queue is not full, set by the parser step in dld_front
// a four-entry command queue lets parser and executor stall independently
// reset (rst_n low, synchronous): parser back to the header, queue and output emptied,
// address, line, entry count and code_units cleared; no clearing pass is needed
module dex_debug_line_program_decoder_unit #(
  parameter int unsigned MAX_ENTRIES = dld_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte stream
  input  logic               in_valid,
  output logic               in_ready,
  input  dld_pkg::in_item_t  in_item,
  // decoded records
  output logic               out_valid,
  input  logic               out_ready,
  output dld_pkg::out_item_t out_item,
  // code_units register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  // commands from the parser and the head of the queue
  dld_pkg::cmd_slot_t push;
  dld_pkg::cmd_slot_t head;
  logic               q_full;
  logic               pop;

  // register write always taken; only done by the user while the decoder is idle, not enforced
  assign cfg_ready = 1'b1;

  // front: splits the stream into header, opcodes and leb operands, and turns each line start,
  // special opcode, address or line advance, prologue and end of sequence into one command
  dld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push)
  );

  // queue: decouples byte intake from record delivery
  dld_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // back: applies commands to the address and line registers, filters line
  // entries against code_units and the entry limit, holds the output item
  dld_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/dld_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the dex debug line program decoder, with its bind
module dld_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input dld_pkg::out_item_t out_item
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("record changed while stalled");

  // last_record marks exactly the end of sequence record
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_record == (out_item.record_kind == dld_pkg::REC_END)))
    else $error("last_record and record_kind disagree");

  // reset leaves no record pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("record pending after reset");

endmodule

bind dex_debug_line_program_decoder_unit dld_checker u_dld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
